// ===== rtl/core/rsl_pkg.sv =====
package rsl_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 128;

   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int COUNT_W = 17;
   localparam int ENTRY_W = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   localparam logic [CFG_W-1:0] REQUEST_LIMIT_RESET  = CFG_W'(100);
   localparam logic [CFG_W-1:0] WINDOW_SECONDS_RESET = CFG_W'(10);

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_REQUEST_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SECONDS = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] source_address;
      logic [TIME_W-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic               block;
      logic               new_entry;
      logic               table_full;
      logic [COUNT_W-1:0] request_total;
      logic [ENTRY_W-1:0] entry_index;
   } rsp_type;

   // one slot of the count/window memory
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  start;
   } slot_entry_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } addr_op_type;

   typedef struct packed {
      logic rd;
      logic update;
      logic create;
   } slot_op_type;

   typedef struct packed {
      logic               block;
      logic [COUNT_W-1:0] total;
   } slot_status_type;

endpackage

// ===== rtl/core/rsl_addr_mem.sv =====
module rsl_addr_mem #(
   parameter int TABLE_DEPTH = rsl_pkg::DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                      clock,
   input  rsl_pkg::addr_op_type      op,
   input  logic [IDX_W-1:0]          idx,
   input  logic [rsl_pkg::ADDR_W-1:0] wr_data,
   input  logic [rsl_pkg::ADDR_W-1:0] key,
   output logic                      match
);

   logic [rsl_pkg::ADDR_W-1:0] mem [TABLE_DEPTH];
   logic [rsl_pkg::ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (op.wr) begin
         mem[idx] <= wr_data;
      end
      if (op.rd) begin
         rd_data_ff <= mem[idx];
      end
   end

   // compare against the slot read in the previous cycle
   assign match = (rd_data_ff == key);

endmodule

// ===== rtl/core/rsl_slot_mem.sv =====
module rsl_slot_mem #(
   parameter int TABLE_DEPTH = rsl_pkg::DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                       clock,
   input  rsl_pkg::slot_op_type       op,
   input  logic [IDX_W-1:0]           idx,
   input  logic [rsl_pkg::TIME_W-1:0] now_seconds,
   input  logic [rsl_pkg::CFG_W-1:0]  request_limit,
   input  logic [rsl_pkg::CFG_W-1:0]  window_seconds,
   output rsl_pkg::slot_status_type   status
);

   rsl_pkg::slot_entry_type mem [TABLE_DEPTH];
   rsl_pkg::slot_entry_type rd_data_ff;
   rsl_pkg::slot_entry_type wr_data;

   logic [rsl_pkg::TIME_W-1:0]  elapsed;
   logic                        in_window;
   logic [rsl_pkg::COUNT_W-1:0] count_inc;

   always_comb begin
      elapsed   = now_seconds - rd_data_ff.start;
      in_window = (elapsed <= rsl_pkg::TIME_W'(window_seconds));
      count_inc = (rd_data_ff.count == rsl_pkg::COUNT_MAX) ? rd_data_ff.count
                                                           : rd_data_ff.count + 1'b1;
      status.block = 1'b0;
      if (op.create || !in_window) begin
         wr_data.count = rsl_pkg::COUNT_ONE;
         wr_data.start = now_seconds;
      end else begin
         wr_data.count = count_inc;
         wr_data.start = rd_data_ff.start;
         status.block  = (count_inc > rsl_pkg::COUNT_W'(request_limit));
      end
      status.total = wr_data.count;
   end

   always_ff @(posedge clock) begin
      if (op.update || op.create) begin
         mem[idx] <= wr_data;
      end
      if (op.rd) begin
         rd_data_ff <= mem[idx];
      end
   end

endmodule

// ===== rtl/core/per_source_rate_limiter.sv =====
// Channel  Ports                              Handshake
// -------  ---------------------------------  ---------------------------------
// request  start, busy, req_payload           beat taken when start & !busy
// result   rsp_strobe, rsp_payload            one-cycle strobe, no back-pressure
// csr      csr_write_enable, csr_index,       written on any edge with enable
//          csr_write_data
//
// One request at a time. The address memory is scanned one slot per cycle, from
// slot 0 through the n slots in use. A hit reads the slot data, then updates it
// and strobes; a miss, or an empty table, appends or reports full and strobes.
// busy drops in the cycle the result is shown; a new beat may be taken there.
// Reset is synchronous: it empties the table by clearing the fill count, with
// no clearing pass, and loads a request limit of 100 and a 10 second window.
// The result side has no stall; results are never held back.
module per_source_rate_limiter #(
   parameter int TABLE_DEPTH = rsl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rsl_pkg::req_type                req_payload,
   output logic                            rsp_strobe,
   output rsl_pkg::rsp_type                rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [rsl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsl_pkg::CFG_W-1:0]       csr_write_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;   // compare slot idx_ff
   localparam logic [1:0] ST_HIT  = 2'd2;   // slot data read, update + reply
   localparam logic [1:0] ST_MISS = 2'd3;   // append or report full

   logic [1:0]                   state_ff, state_in;
   logic [rsl_pkg::ADDR_W-1:0]   key_ff, key_in;
   logic [rsl_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [rsl_pkg::CFG_W-1:0]    max_req_ff, max_req_in;
   logic [rsl_pkg::CFG_W-1:0]    window_ff, window_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   rsl_pkg::rsp_type             rsp_ff, rsp_in;

   rsl_pkg::addr_op_type         addr_op;
   logic [IDX_W-1:0]             addr_idx;
   logic                         addr_match;
   rsl_pkg::slot_op_type         slot_op;
   logic [IDX_W-1:0]             slot_idx;
   rsl_pkg::slot_status_type     slot_status;

   logic [IDX_W-1:0]             idx_next;
   logic                         last_slot;
   logic [rsl_pkg::ENTRY_W+IDX_W-1:0] hit_index_ext;
   logic [rsl_pkg::ENTRY_W+CNT_W-1:0] new_index_ext;

   rsl_addr_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_addr_mem (
      .clock   (clock),
      .op      (addr_op),
      .idx     (addr_idx),
      .wr_data (key_ff),
      .key     (key_ff),
      .match   (addr_match)
   );

   rsl_slot_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_slot_mem (
      .clock          (clock),
      .op             (slot_op),
      .idx            (slot_idx),
      .now_seconds    (now_ff),
      .request_limit  (max_req_ff),
      .window_seconds (window_ff),
      .status         (slot_status)
   );

   assign idx_next      = idx_ff + 1'b1;
   assign last_slot     = ((CNT_W'(idx_ff) + 1'b1) == used_ff);
   // entry_index keeps the low bits of the slot number
   assign hit_index_ext = (rsl_pkg::ENTRY_W+IDX_W)'(idx_ff);
   assign new_index_ext = (rsl_pkg::ENTRY_W+CNT_W)'(used_ff);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      addr_op       = '0;
      addr_idx      = idx_ff;
      slot_op       = '0;
      slot_idx      = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_payload.source_address;
               now_in = req_payload.now_seconds;
               idx_in = '0;
               if (used_ff == '0) begin
                  state_in = ST_MISS;
               end else begin
                  addr_op.rd = 1'b1;
                  addr_idx   = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (addr_match) begin
               slot_op.rd = 1'b1;
               state_in   = ST_HIT;
            end else if (last_slot) begin
               state_in = ST_MISS;
            end else begin
               idx_in     = idx_next;
               addr_op.rd = 1'b1;
               addr_idx   = idx_next;
            end
         end
         ST_HIT: begin
            slot_op.update       = 1'b1;
            rsp_strobe_in        = 1'b1;
            rsp_in.block         = slot_status.block;
            rsp_in.new_entry     = 1'b0;
            rsp_in.table_full    = 1'b0;
            rsp_in.request_total = slot_status.total;
            rsp_in.entry_index   = hit_index_ext[rsl_pkg::ENTRY_W-1:0];
            state_in             = ST_IDLE;
         end
         ST_MISS: begin
            rsp_strobe_in = 1'b1;
            rsp_in.block  = 1'b0;
            state_in      = ST_IDLE;
            if (used_ff == FULL_COUNT) begin
               rsp_in.new_entry     = 1'b0;
               rsp_in.table_full    = 1'b1;
               rsp_in.request_total = '0;
               rsp_in.entry_index   = '0;
            end else begin
               addr_op.wr           = 1'b1;
               addr_idx             = used_ff[IDX_W-1:0];
               slot_op.create       = 1'b1;
               slot_idx             = used_ff[IDX_W-1:0];
               used_in              = used_ff + 1'b1;
               rsp_in.new_entry     = 1'b1;
               rsp_in.table_full    = 1'b0;
               rsp_in.request_total = rsl_pkg::COUNT_ONE;
               rsp_in.entry_index   = new_index_ext[rsl_pkg::ENTRY_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // csr writes; the host must keep them to periods with no request in flight, as the block has no check for it
   always_comb begin
      max_req_in = max_req_ff;
      window_in  = window_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rsl_pkg::REG_REQUEST_LIMIT:  max_req_in = csr_write_data;
            rsl_pkg::REG_WINDOW_SECONDS: window_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         max_req_ff    <= rsl_pkg::REQUEST_LIMIT_RESET;
         window_ff     <= rsl_pkg::WINDOW_SECONDS_RESET;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
         max_req_ff    <= max_req_in;
         window_ff     <= window_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      now_ff <= now_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/rsl_checker.sv =====
module rsl_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input rsl_pkg::rsp_type rsp_payload
);

   // a taken beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // results are shown only once the block has finished
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.table_full) |->
         (!rsp_payload.block && !rsp_payload.new_entry &&
          rsp_payload.request_total == '0 && rsp_payload.entry_index == '0))
      else $error("table-full result not clean");

   a_new_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.new_entry) |->
         (!rsp_payload.block && !rsp_payload.table_full &&
          rsp_payload.request_total == rsl_pkg::COUNT_ONE))
      else $error("new entry result not count one");

endmodule

bind per_source_rate_limiter rsl_checker u_rsl_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
